### hdl/nltl_pkg.sv
// Package for the line track linker: request and status codes, field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nltl_pkg;
    localparam int unsigned TW = 24;
    localparam int unsigned LW = 23;
    localparam int unsigned ERRW = 64;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_SCAN  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_NO_CAND  = 3'd1,
        ST_WAIT     = 3'd2,
        ST_REJECTED = 3'd3,
        ST_APPENDED = 3'd4
    } t_status;

    localparam logic [1:0] CFG_TIME_W = 2'd0;
    localparam logic [1:0] CFG_FREQ_W = 2'd1;
    localparam logic [1:0] CFG_TOL    = 2'd2;
    localparam logic [1:0] CFG_DELAY  = 2'd3;

    typedef struct packed {
        logic signed [TW-1:0] start;
        logic signed [TW-1:0] freq;
        logic signed [TW-1:0] slope;
        logic        [LW-1:0] length;
    } t_line;
endpackage
`default_nettype wire

### hdl/nltl_dist.sv
// Distance pipeline: gap, frequency offset and weighted squared error per entry.
// Depends on nltl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nltl_dist
    import nltl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_valid,
    input  wire logic signed [TW-1:0]  i_start,
    input  wire logic signed [TW-1:0]  i_freq,
    input  wire logic signed [TW+1:0]  i_end_t,
    input  wire logic signed [47:0]    i_end_f,
    input  wire logic        [15:0]    i_tw,
    input  wire logic        [15:0]    i_fw,
    output logic                       o_valid,
    output logic signed [TW+2:0]       o_gap,
    output logic        [ERRW-1:0]     o_err
);
    logic               r_v1, r_v2, r_v3;
    logic signed [TW+2:0] r_gap1, r_gap2, r_gap3;
    logic        [31:0] r_ag, r_af;
    logic        [63:0] r_sg, r_sf;
    logic        [ERRW-1:0] r_wg, r_wf;
    logic signed [48:0] n_fd;
    logic signed [TW+2:0] n_gap;

    always_comb begin
        n_gap = (TW+3)'(i_start) - (TW+3)'(i_end_t);
        n_fd  = 49'(i_freq) - 49'(i_end_f);
    end

    always_ff @(posedge i_clk) begin
        r_v1   <= i_valid;
        r_gap1 <= n_gap;
        r_ag   <= n_gap[TW+2] ? 32'(-n_gap) : 32'(n_gap);
        r_af   <= n_fd[48] ? 32'(-n_fd) : 32'(n_fd);
        r_v2   <= r_v1;
        r_gap2 <= r_gap1;
        r_sg   <= r_ag * r_ag;
        r_sf   <= r_af * r_af;
        r_v3   <= r_v2;
        r_gap3 <= r_gap2;
        r_wg   <= 64'(r_sg[63:16]) * 64'(i_tw) + 64'((64'(r_sg[15:0]) * 64'(i_tw)) >> 16);
        r_wf   <= 64'(r_sf[63:16]) * 64'(i_fw) + 64'((64'(r_sf[15:0]) * 64'(i_fw)) >> 16);
        o_valid <= r_v3;
        o_gap  <= r_gap3;
        o_err  <= r_wg + r_wf;
    end
endmodule
`default_nettype wire

### hdl/nearest_line_track_linker_top.sv
// Line track linker top: line memory, free bits, scan sequencer, result strobe.
// Depends on nltl_pkg and nltl_dist.
// Write, start and code three pass through S_RD, S_LOAD and S_OUT; scan then continues in S_SCAN,
// with one memory read per entry through the distance pipeline, then S_DEC, S_RD, S_LOAD and S_OUT.
// One request at a time; busy is high from accept until the strobe cycle, results never stall.
// Synchronous active-low reset clears free bits, tail, id counter and config registers.
`timescale 1ns / 1ps
`default_nettype none
module nearest_line_track_linker_top
    import nltl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [7:0]           i_line_index,
    input  wire logic signed [23:0]   i_line_start,
    input  wire logic signed [23:0]   i_line_freq,
    input  wire logic signed [23:0]   i_line_slope,
    input  wire logic [22:0]          i_line_length,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    output logic                      o_strobe,
    output logic [2:0]                o_status,
    output logic [31:0]               o_event_number,
    output logic [7:0]                o_linked_index
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_LOAD = 6'b000100,
        S_SCAN = 6'b001000,
        S_DEC  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_line          mem [TABLE_DEPTH];
    t_line          r_rd;
    logic [TABLE_DEPTH-1:0] r_free;
    t_state         r_state;
    t_line          r_tail;
    logic [31:0]    r_id;
    logic [15:0]    r_tw, r_fw;
    logic [51:0]    r_tol;
    logic signed [25:0] r_delay;
    t_req           r_req;
    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  r_addr;
    logic [AW-1:0]  r_addr_d;
    logic [AW-1:0]  r_pipe_idx [4];
    logic [3:0]     r_pipe_f;
    logic           r_found;
    logic [AW-1:0]  r_best;
    logic [ERRW-1:0] r_best_err;
    logic signed [TW+2:0] r_min_gap;
    logic signed [TW+1:0] r_end_t;
    logic signed [47:0] r_end_f;
    logic           r_rd_v;
    logic           r_rd_ok;
    t_status        r_status;

    logic           d_valid;
    logic signed [TW+2:0] d_gap;
    logic [ERRW-1:0] d_err;
    logic           d_err_best_gt;
    logic           in_range;
    logic signed [47:0] n_prod;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_range = (32'(i_line_index) < TABLE_DEPTH);
    assign n_prod = 48'(r_tail.slope) * 48'($signed({1'b0, r_tail.length}));
    assign d_err_best_gt = (r_best_err > 64'(r_tol));

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_req_type == REQ_WRITE && in_range) begin
            mem[AW'(i_line_index)] <= t_line'{i_line_start, i_line_freq, i_line_slope,
                                                i_line_length};
        end
        r_rd <= mem[r_addr];
    end

    nltl_dist u_dist (
        .i_clk   (i_clk),
        .i_valid (r_rd_ok),
        .i_start (r_rd.start),
        .i_freq  (r_rd.freq),
        .i_end_t (r_end_t),
        .i_end_f (r_end_f),
        .i_tw    (r_tw),
        .i_fw    (r_fw),
        .o_valid (d_valid),
        .o_gap   (d_gap),
        .o_err   (d_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '0;
            r_tail  <= '0;
            r_id    <= '0;
            r_tw    <= '0;
            r_fw    <= '0;
            r_tol   <= '0;
            r_delay <= '0;
            o_strobe <= 1'b0;
            r_rd_v  <= 1'b0;
            r_rd_ok <= 1'b0;
            r_pipe_f <= '0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TIME_W: r_tw <= i_cfg_data[15:0];
                    CFG_FREQ_W: r_fw <= i_cfg_data[15:0];
                    CFG_TOL:    r_tol <= i_cfg_data[51:0];
                    CFG_DELAY:  r_delay <= i_cfg_data[25:0];
                    default:    r_tw <= r_tw;
                endcase
            end
            r_rd_ok  <= r_rd_v;
            r_pipe_f <= {r_pipe_f[2:0], r_rd_ok & r_free[r_addr_d]};
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req  <= t_req'(i_req_type);
                        r_addr <= AW'(i_line_index);
                        r_status <= ST_ACCEPTED;
                        r_found <= 1'b0;
                        r_cnt  <= '0;
                        r_state <= S_RD;
                        if (i_req_type == REQ_WRITE || i_req_type == REQ_START) begin
                            if (!in_range) r_status <= ST_NO_CAND;
                            else if (i_req_type == REQ_WRITE)
                                r_free[AW'(i_line_index)] <= 1'b1;
                        end
                        if (i_req_type == REQ_SCAN) begin
                            r_addr <= '0;
                        end
                    end
                end
                S_RD: begin
                    r_end_t <= (TW+2)'(r_tail.start) + (TW+2)'($signed({1'b0, r_tail.length}));
                    r_state <= (r_req == REQ_SCAN) ? S_SCAN : S_LOAD;
                    if (r_req == REQ_SCAN) r_rd_v <= 1'b1;
                end
                S_LOAD: begin
                    if (r_req == REQ_START && r_status == ST_ACCEPTED) begin
                        r_tail <= r_rd;
                        r_id   <= r_id + 32'd1;
                    end
                    if (r_status == ST_APPENDED) r_tail <= r_rd;
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    if (r_rd_v) begin
                        if (r_addr == AW'(TABLE_DEPTH - 1)) r_rd_v <= 1'b0;
                        else r_addr <= r_addr + AW'(1);
                    end
                    if (d_valid) begin
                        r_cnt <= r_cnt + CW'(1);
                        if (r_pipe_f[3]) begin
                            r_found <= 1'b1;
                            if (!r_found || d_gap < r_min_gap) r_min_gap <= d_gap;
                            if (!r_found || d_err < r_best_err) begin
                                r_best_err <= d_err;
                                r_best <= r_pipe_idx[3];
                            end
                        end
                        if (r_cnt == CW'(TABLE_DEPTH - 1)) begin
                            r_state <= S_DEC;
                            r_addr <= r_best;
                        end
                    end
                end
                S_DEC: begin
                    r_addr <= r_best;
                    if (!r_found) r_status <= ST_NO_CAND;
                    else if (28'(r_min_gap) > 28'(r_delay)) r_status <= ST_WAIT;
                    else if (d_err_best_gt) r_status <= ST_REJECTED;
                    else r_status <= ST_APPENDED;
                    r_state <= S_RD;
                    r_req <= REQ_NONE;
                end
                S_OUT: begin
                    if (r_status == ST_APPENDED) r_free[r_best] <= 1'b0;
                    o_strobe <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_d <= r_addr;
        r_pipe_idx[0] <= r_addr_d;
        for (int k = 1; k < 4; k++) r_pipe_idx[k] <= r_pipe_idx[k-1];
        if (r_state == S_RD) r_end_f <= 48'(r_tail.freq) + (n_prod >>> 16);
        if (r_state == S_LOAD || r_state == S_IDLE) begin
            o_status <= r_status;
            o_event_number <= (r_state == S_LOAD && r_req == REQ_START
                               && r_status == ST_ACCEPTED) ? r_id + 32'd1 : r_id;
            o_linked_index <= (r_status == ST_APPENDED) ? 8'(r_best) : 8'd0;
        end
    end

`ifndef SYNTHESIS
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("double strobe");
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("strobe while busy");
    a_link_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_APPENDED) |-> !r_free[r_best])
        else $error("linked entry still free");
`endif
endmodule
`default_nettype wire

### test/nearest_line_track_linker_top_test.sv
// Self-checking bench for nearest_line_track_linker_top: drives table writes, event starts
// and scans, predicts each result in a scoreboard class and compares field by field.
// Depends on nltl_pkg and the linker RTL.
`timescale 1ns / 1ps
module nearest_line_track_linker_top_test;
    import nltl_pkg::*;

    localparam int unsigned DEPTH = 256;

    class linker_scoreboard;
        t_line   lines[DEPTH];
        bit      free_mark[DEPTH];
        bit      written[DEPTH];
        t_line   tail;
        bit [31:0] event_id;
        bit [15:0] time_w, freq_w;
        bit [51:0] tol_sq;
        logic signed [25:0] delay_lim;
        t_status exp_status[$];
        bit [31:0] exp_event[$];
        bit [7:0]  exp_link[$];
        int mismatches;
        int checked;
        int n_status[8];

        function new();
            foreach (free_mark[i]) begin
                free_mark[i] = 0;
                written[i] = 0;
            end
            tail = '0;
            event_id = 0;
            time_w = 0;
            freq_w = 0;
            tol_sq = 0;
            delay_lim = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                CFG_TIME_W: time_w = val[15:0];
                CFG_FREQ_W: freq_w = val[15:0];
                CFG_TOL:    tol_sq = val[51:0];
                default:    delay_lim = val[25:0];
            endcase
        endfunction

        function bit [63:0] weigh_sq(longint a, bit [15:0] w);
            bit [127:0] p;
            bit [63:0] m;
            m = (a < 0) ? -a : a;
            p = m * m * w;
            return p[79:16];
        endfunction

        function void note_request(t_req req, bit [7:0] idx, t_line ln);
            t_status st;
            bit [7:0] lk;
            longint end_t, end_f, prod, gap, fd, min_gap;
            bit [63:0] err, best_err;
            bit found;
            int best;
            st = ST_ACCEPTED;
            lk = 0;
            found = 0;
            best = 0;
            best_err = 0;
            min_gap = 0;
            case (req)
                REQ_WRITE: begin
                    lines[idx] = ln;
                    free_mark[idx] = 1;
                    written[idx] = 1;
                end
                REQ_START: begin
                    event_id++;
                    tail = lines[idx];
                end
                REQ_SCAN: begin
                    end_t = longint'(tail.start) + longint'({1'b0, tail.length});
                    prod = longint'(tail.slope) * longint'({1'b0, tail.length});
                    end_f = longint'(tail.freq) + (prod >>> 16);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (free_mark[i]) begin
                            gap = longint'(lines[i].start) - end_t;
                            fd = longint'(lines[i].freq) - end_f;
                            err = weigh_sq(gap, time_w) + weigh_sq(fd, freq_w);
                            if (!found || gap < min_gap) min_gap = gap;
                            if (!found || err < best_err) begin
                                best_err = err;
                                best = i;
                            end
                            found = 1;
                        end
                    end
                    if (!found) st = ST_NO_CAND;
                    else if (min_gap > longint'(delay_lim)) st = ST_WAIT;
                    else if (best_err > {12'b0, tol_sq}) st = ST_REJECTED;
                    else begin
                        tail = lines[best];
                        free_mark[best] = 0;
                        st = ST_APPENDED;
                        lk = best[7:0];
                    end
                end
                default: ;
            endcase
            exp_status = {exp_status, st};
            exp_event = {exp_event, event_id};
            exp_link = {exp_link, lk};
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] ev, logic [7:0] lk);
            t_status es;
            bit [31:0] ee;
            bit [7:0] el;
            if (exp_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with nothing expected");
                return;
            end
            es = exp_status.pop_front();
            ee = exp_event.pop_front();
            el = exp_link.pop_front();
            checked++;
            n_status[es]++;
            if (st !== es || ev !== ee || lk !== el) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: status %0d/%0d event %0d/%0d link %0d/%0d (exp/act)",
                             es, st, ee, ev, el, lk);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] i_req_type = 0;
    logic [7:0] i_line_index = 0;
    logic signed [23:0] i_line_start = 0, i_line_freq = 0, i_line_slope = 0;
    logic [22:0] i_line_length = 0;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = 0;
    logic [63:0] i_cfg_data = 0;
    logic o_strobe;
    logic [2:0] o_status;
    logic [31:0] o_event_number;
    logic [7:0] o_linked_index;

    linker_scoreboard sb = new();
    int idle_pct = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    nearest_line_track_linker_top #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

    always @(posedge i_clk)
        if (i_rst_n && o_strobe) sb.check_result(o_status, o_event_number, o_linked_index);

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_request(t_req req, bit [7:0] idx, t_line ln);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_req_type <= req;
        i_line_index <= idx;
        i_line_start <= ln.start;
        i_line_freq <= ln.freq;
        i_line_slope <= ln.slope;
        i_line_length <= ln.length;
        do @(posedge i_clk); while (busy);
        sb.note_request(req, idx, ln);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int n;
        start <= 0;
        n = 0;
        while (sb.exp_status.size() != 0 && n < 2000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (DEPTH + 20) @(negedge i_clk);
    endtask

    task automatic set_all(bit [15:0] tw, bit [15:0] fw, bit [51:0] tol, logic [25:0] dl);
        write_reg(CFG_TIME_W, 64'(tw));
        write_reg(CFG_FREQ_W, 64'(fw));
        write_reg(CFG_TOL, 64'(tol));
        write_reg(CFG_DELAY, {{38{dl[25]}}, dl});
        i_cfg_valid <= 0;
    endtask

    function automatic t_line rand_line(bit narrow);
        t_line ln;
        if (narrow) begin
            ln.start = 24'($urandom_range(2000) - 1000);
            ln.freq = 24'($urandom_range(2000) - 1000);
            ln.slope = 24'($urandom_range(262144) - 131072);
            ln.length = 23'($urandom_range(200));
        end else begin
            ln.start = 24'($urandom);
            ln.freq = 24'($urandom);
            ln.slope = 24'($urandom);
            ln.length = 23'($urandom);
        end
        return ln;
    endfunction

    function automatic bit [7:0] written_index();
        bit [7:0] k;
        do k = 8'($urandom); while (!sb.written[k]);
        return k;
    endfunction

    task automatic random_phase(int count, int pct);
        t_line ln;
        int r;
        bit [7:0] k;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            ln = rand_line($urandom_range(9) != 0);
            k = 8'($urandom_range(15));
            if (r < 45) send_request(REQ_WRITE, k, ln);
            else if (r < 55) send_request(REQ_START, written_index(), ln);
            else if (r < 95) send_request(REQ_SCAN, 8'($urandom), ln);
            else send_request(REQ_NONE, 8'($urandom), ln);
        end
        drain();
    endtask

    initial begin
        t_line ln;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // empty table, then extremes of every field
        send_request(REQ_SCAN, 0, '0);
        send_request(REQ_NONE, 8'hff, '1);
        ln = '{24'sh7fffff, 24'sh800000, 24'sh7fffff, 23'h7fffff};
        send_request(REQ_WRITE, 8'd255, ln);
        ln = '{24'sh800000, 24'sh7fffff, 24'sh800000, 23'd0};
        send_request(REQ_WRITE, 8'd0, ln);
        send_request(REQ_START, 8'd255, '0);
        send_request(REQ_SCAN, 0, '0);
        drain();
        set_all(16'hffff, 16'hffff, {52{1'b1}}, 26'h1ffffff);
        send_request(REQ_SCAN, 0, '0);
        send_request(REQ_START, 8'd0, '0);
        send_request(REQ_SCAN, 0, '0);
        ln = '{24'sd10, 24'sd5, 24'sd0, 23'd3};
        send_request(REQ_WRITE, 8'd1, ln);
        send_request(REQ_WRITE, 8'd2, ln);
        send_request(REQ_START, 8'd1, '0);
        send_request(REQ_SCAN, 0, '0);
        send_request(REQ_SCAN, 0, '0);
        drain();
        set_all(16'd0, 16'd0, 52'd0, 26'h2000000);
        send_request(REQ_SCAN, 0, '0);
        drain();
        set_all(16'd1, 16'd0, 52'd0, 26'd0);
        send_request(REQ_SCAN, 0, '0);
        drain();
        set_all(16'd300, 16'd500, 52'd4000, 26'd50);
        random_phase(250, 0);
        set_all(16'hffff, 16'd20, 52'd100000, 26'd500);
        random_phase(250, 58);
        set_all(16'd40, 16'hffff, 52'd1000, 26'h3fffff0);
        random_phase(250, 32);
        set_all(16'($urandom), 16'($urandom), 52'({$urandom, $urandom}), 26'($urandom));
        random_phase(250, 0);
        $display("Checked %0d results: %0d appended, %0d rejected, %0d wait, %0d none.",
                 sb.checked, sb.n_status[ST_APPENDED], sb.n_status[ST_REJECTED],
                 sb.n_status[ST_WAIT], sb.n_status[ST_NO_CAND]);
        if (sb.mismatches == 0 && sb.exp_status.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### nearest_line_track_linker_top.f
hdl/nltl_pkg.sv
hdl/nltl_dist.sv
hdl/nearest_line_track_linker_top.sv
test/nearest_line_track_linker_top_test.sv
